FILE: design/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is applied
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// concurrent check that also runs through reset
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: design/ppd_pkg.sv
// ---------------------------------------------------------------------------
// ppd_pkg
// Types and constants shared by the packed packet-header deframer.
// ---------------------------------------------------------------------------
package ppd_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_LEN_TRUNC  = 2'd1,
        ERR_UNFINISHED = 2'd2,
        ERR_TOO_MANY   = 2'd3
    } t_err;

    // bytes in one big-endian length field
    localparam int unsigned LEN_FIELD_BYTES = 4;
    localparam int unsigned LEN_CNT_W       = $clog2(LEN_FIELD_BYTES);

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [15:0] tile_number;
        logic [31:0] header_length;
        logic [31:0] byte_in_header;
        logic [31:0] merged_offset;
        logic [7:0]  payload_byte;
        t_err        error_code;
    } t_result;

    // one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_end;
        logic       stream_end;
    } t_item;

endpackage

FILE: design/ppd_step.sv
// ---------------------------------------------------------------------------
// ppd_step
// Deframing state and the combinational update that turns one byte into
// one result: length assembly, payload tracking and error detection.
// ---------------------------------------------------------------------------
module ppd_step
    import ppd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic [LEN_CNT_W-1:0] r_len_cnt,  n_len_cnt;
    logic [31:0]          r_len_acc,  n_len_acc;
    logic [31:0]          r_remain,   n_remain;
    logic [31:0]          r_position, n_position;
    logic [16:0]          r_tiles,    n_tiles;
    logic [31:0]          r_merged,   n_merged;
    logic                 r_error,    n_error;

    logic [15:0] tile_prev;

    assign tile_prev = r_tiles[15:0] - 16'd1;

    // next state and result for the byte in the input register
    always_comb begin
        n_len_cnt  = r_len_cnt;
        n_len_acc  = r_len_acc;
        n_remain   = r_remain;
        n_position = r_position;
        n_tiles    = r_tiles;
        n_merged   = r_merged;
        n_error    = r_error;
        o_result   = '0;

        if (!r_error) begin
            if (r_remain != 32'd0) begin
                // payload byte of the current tile header
                o_result.kind           = KIND_PAYLOAD;
                o_result.tile_number    = tile_prev;
                o_result.header_length  = r_len_acc;
                o_result.byte_in_header = r_position;
                o_result.merged_offset  = r_merged;
                o_result.payload_byte   = i_item.data_byte;
                n_remain   = r_remain - 32'd1;
                n_position = r_position + 32'd1;
                n_merged   = r_merged + 32'd1;
            end else begin
                // length field byte, most significant first
                if (r_len_cnt == '0) begin
                    n_len_acc = {24'd0, i_item.data_byte};
                end else begin
                    n_len_acc = {r_len_acc[23:0], i_item.data_byte};
                end
                n_len_cnt = r_len_cnt + LEN_CNT_W'(1);
                if (r_len_cnt == LEN_CNT_W'(LEN_FIELD_BYTES - 1)) begin
                    if (r_tiles[16]) begin
                        o_result            = '0;
                        o_result.kind       = KIND_ERROR;
                        o_result.error_code = ERR_TOO_MANY;
                        n_error             = 1'b1;
                    end else begin
                        o_result.kind          = KIND_HEADER;
                        o_result.tile_number   = r_tiles[15:0];
                        o_result.header_length = n_len_acc;
                        o_result.merged_offset = r_merged;
                        n_tiles    = r_tiles + 17'd1;
                        n_remain   = n_len_acc;
                        n_position = 32'd0;
                    end
                end
            end

            // framing errors at segment or stream end
            if (!n_error) begin
                if ((i_item.segment_end || i_item.stream_end) && n_len_cnt != '0) begin
                    o_result            = '0;
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_LEN_TRUNC;
                    n_error             = 1'b1;
                end else if (i_item.stream_end && n_remain != 32'd0) begin
                    o_result            = '0;
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_UNFINISHED;
                    n_error             = 1'b1;
                end
            end
        end

        // stream end returns everything to reset
        if (i_item.stream_end) begin
            n_len_cnt  = '0;
            n_len_acc  = '0;
            n_remain   = '0;
            n_position = '0;
            n_tiles    = '0;
            n_merged   = '0;
            n_error    = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cnt  <= '0;
            r_len_acc  <= '0;
            r_remain   <= '0;
            r_position <= '0;
            r_tiles    <= '0;
            r_merged   <= '0;
            r_error    <= 1'b0;
        end else if (i_advance) begin
            r_len_cnt  <= n_len_cnt;
            r_len_acc  <= n_len_acc;
            r_remain   <= n_remain;
            r_position <= n_position;
            r_tiles    <= n_tiles;
            r_merged   <= n_merged;
            r_error    <= n_error;
        end
    end

endmodule

FILE: design/ppd_out_reg.sv
// ---------------------------------------------------------------------------
// ppd_out_reg
// Result register with valid/stall flow control; it can be reloaded in the
// same cycle its current result is taken.
// ---------------------------------------------------------------------------
module ppd_out_reg
    import ppd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load_valid,
    input  t_result i_result,
    output logic    o_can_load,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // room when empty or when the held result leaves this cycle
    assign o_can_load = !r_valid || !i_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/ppm_packet_header_deframer.sv
// ---------------------------------------------------------------------------
// ppm_packet_header_deframer
// Splits packed packet-header marker data into tile header announcements
// and payload bytes.
// ---------------------------------------------------------------------------
// Takes one marker-segment data byte per transfer and gives exactly one
// result per byte, kind 0 to 3. A byte sits first in the input register,
// is processed by the combinational deframing logic and lands in the result
// register. One byte is taken every cycle while the result side does not
// stall; the rate is set by the single combinational update of the length
// and payload counters. A stall on the result side propagates back to the
// input within the same cycle once both registers are full. Errors hold the
// block silent until the stream-end byte.
module ppm_packet_header_deframer
    import ppd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_segment_end,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_tile_number,
    output logic [31:0] o_header_length,
    output logic [31:0] o_byte_in_header,
    output logic [31:0] o_merged_offset,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_error_code
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    out_can_load;
    logic    advance;
    t_result step_result;
    t_result out_result;

    assign advance = r_in_valid && out_can_load;
    assign o_stall = r_in_valid && !out_can_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_item <= '{data_byte: i_data_byte, segment_end: i_segment_end,
                           stream_end: i_stream_end};
        end
    end

    // deframing logic and state
    ppd_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (step_result)
    );

    // result register
    ppd_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_result     (step_result),
        .o_can_load   (out_can_load),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_kind           = out_result.kind;
    assign o_tile_number    = out_result.tile_number;
    assign o_header_length  = out_result.header_length;
    assign o_byte_in_header = out_result.byte_in_header;
    assign o_merged_offset  = out_result.merged_offset;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_error_code     = out_result.error_code;

endmodule

FILE: design/ppd_checker.sv
// ---------------------------------------------------------------------------
// ppd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ppd_checker
    import ppd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [15:0] o_tile_number,
    input logic [31:0] o_header_length,
    input logic [31:0] o_byte_in_header,
    input logic [31:0] o_merged_offset,
    input logic [7:0]  o_payload_byte,
    input logic [1:0]  o_error_code
);

    // reset empties the result register
    `ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> !o_valid)

    // a stalled result stays valid
    `ASSERT_CLK_RST(a_valid_held, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)

    // an error result carries a code and no tile number, length or merged offset
    `ASSERT_CLK_RST(a_error_clean, i_clk, i_rst_n,
        o_valid && o_kind == KIND_ERROR |-> o_error_code != ERR_NONE &&
        o_tile_number == 16'd0 && o_header_length == 32'd0 && o_merged_offset == 32'd0)

    // only error results carry a code
    `ASSERT_CLK_RST(a_code_only_on_error, i_clk, i_rst_n,
        o_valid && o_kind != KIND_ERROR |-> o_error_code == ERR_NONE)

    // an empty result has zero tile number, length, position and payload byte
    `ASSERT_CLK_RST(a_none_zero, i_clk, i_rst_n,
        o_valid && o_kind == KIND_NONE |-> o_tile_number == 16'd0 &&
        o_header_length == 32'd0 && o_byte_in_header == 32'd0 && o_payload_byte == 8'd0)

endmodule

bind ppm_packet_header_deframer ppd_checker u_ppd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_tile_number    (o_tile_number),
    .o_header_length  (o_header_length),
    .o_byte_in_header (o_byte_in_header),
    .o_merged_offset  (o_merged_offset),
    .o_payload_byte   (o_payload_byte),
    .o_error_code     (o_error_code)
);

FILE: sim/ppm_packet_header_deframer_tb.sv
// ---------------------------------------------------------------------------
// ppm_packet_header_deframer_tb
// Self-checking bench for the packed packet-header deframer: marker-segment
// bytes go in through a valid/stall driver and every result is compared,
// field by field, with a cycle-free model of the length/payload framing.
// ---------------------------------------------------------------------------
module ppm_packet_header_deframer_tb
    import ppd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT     = 29;
    localparam int unsigned TILE_LIMIT   = 65536;
    localparam int unsigned CALM_ITEMS   = 200;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned PAUSE_EVERY  = 350;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_segment_end = 1'b0;
    logic        i_stream_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_tile_number;
    logic [31:0] o_header_length;
    logic [31:0] o_byte_in_header;
    logic [31:0] o_merged_offset;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_error_code;

    // bytes waiting to be sent, results owed by the block
    t_item   byte_q[$];
    t_result pending_results[$];
    t_item   cur_item;

    // deframer state as the block should hold it
    logic [2:0]  len_seen;
    logic [31:0] len_acc;
    logic [31:0] pay_left;
    logic [31:0] pay_pos;
    logic [16:0] tiles;
    logic [31:0] merged;
    logic        err_hold;

    bit calm = 1'b0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned headers_seen = 0;
    int unsigned payload_seen = 0;
    int unsigned errors_seen[4] = '{0, 0, 0, 0};

    ppm_packet_header_deframer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_segment_end    (i_segment_end),
        .i_stream_end     (i_stream_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_tile_number    (o_tile_number),
        .o_header_length  (o_header_length),
        .o_byte_in_header (o_byte_in_header),
        .o_merged_offset  (o_merged_offset),
        .o_payload_byte   (o_payload_byte),
        .o_error_code     (o_error_code)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // framing model
    // -----------------------------------------------------------------------

    function automatic void clear_deframer();
        len_seen = '0;
        len_acc  = '0;
        pay_left = '0;
        pay_pos  = '0;
        tiles    = '0;
        merged   = '0;
        err_hold = 1'b0;
    endfunction

    function automatic t_result error_result(t_err code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        err_hold     = 1'b1;
        return r;
    endfunction

    function automatic t_result deframe_byte(t_item it);
        t_result     r;
        logic [16:0] tile_m1;
        r = '0;
        // silent until the stream-end byte once an error has been raised
        if (err_hold) begin
            if (it.stream_end)
                clear_deframer();
            return r;
        end
        if (pay_left != 0) begin
            tile_m1          = tiles - 17'd1;
            r.kind           = KIND_PAYLOAD;
            r.tile_number    = tile_m1[15:0];
            r.header_length  = len_acc;
            r.byte_in_header = pay_pos;
            r.merged_offset  = merged;
            r.payload_byte   = it.data_byte;
            pay_left         = pay_left - 32'd1;
            pay_pos          = pay_pos + 32'd1;
            merged           = merged + 32'd1;
        end else begin
            // big-endian length assembly
            if (len_seen == 0)
                len_acc = {24'd0, it.data_byte};
            else
                len_acc = {len_acc[23:0], it.data_byte};
            len_seen = len_seen + 3'd1;
            if (len_seen >= LEN_FIELD_BYTES) begin
                len_seen = '0;
                if (tiles >= TILE_LIMIT) begin
                    r = error_result(ERR_TOO_MANY);
                end else begin
                    r.kind          = KIND_HEADER;
                    r.tile_number   = tiles[15:0];
                    r.header_length = len_acc;
                    r.merged_offset = merged;
                    tiles           = tiles + 17'd1;
                    pay_left        = len_acc;
                    pay_pos         = '0;
                end
            end
        end
        // end-of-segment and end-of-stream checks
        if (!err_hold) begin
            if ((it.segment_end || it.stream_end) && len_seen != 0)
                r = error_result(ERR_LEN_TRUNC);
            else if (it.stream_end && pay_left != 0)
                r = error_result(ERR_UNFINISHED);
        end
        if (it.stream_end)
            clear_deframer();
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // driver: one byte per transfer, random gaps unless calm
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_results = {pending_results, deframe_byte(cur_item)};
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_item      = byte_q.pop_front();
                    i_valid       <= 1'b1;
                    i_data_byte   <= cur_item.data_byte;
                    i_segment_end <= cur_item.segment_end;
                    i_stream_end  <= cur_item.stream_end;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // monitor: random stall, compare every accepted result
    // -----------------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (exp_val !== got_val) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
        end
    endtask

    t_result exp_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $error("result transfer with no byte outstanding");
                end else begin
                    exp_res = pending_results.pop_front();
                    results_seen++;
                    case (exp_res.kind)
                        KIND_HEADER:  headers_seen++;
                        KIND_PAYLOAD: payload_seen++;
                        KIND_ERROR:   errors_seen[exp_res.error_code]++;
                        default:      ;
                    endcase
                    check_field("kind", 32'(exp_res.kind), 32'(o_kind));
                    check_field("tile_number", 32'(exp_res.tile_number),
                                32'(o_tile_number));
                    check_field("header_length", exp_res.header_length, o_header_length);
                    check_field("byte_in_header", exp_res.byte_in_header, o_byte_in_header);
                    check_field("merged_offset", exp_res.merged_offset, o_merged_offset);
                    check_field("payload_byte", 32'(exp_res.payload_byte),
                                32'(o_payload_byte));
                    check_field("error_code", 32'(exp_res.error_code), 32'(o_error_code));
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // -----------------------------------------------------------------------
    // stimulus building
    // -----------------------------------------------------------------------

    task automatic add_byte(logic [7:0] b, logic seg_end, logic str_end);
        t_item it;
        it.data_byte   = b;
        it.segment_end = seg_end;
        it.stream_end  = str_end;
        byte_q = {byte_q, it};
    endtask

    // four-byte length, flags on the final byte only
    task automatic add_length(logic [31:0] len, logic seg_end, logic str_end);
        add_byte(len[31:24], 1'b0, 1'b0);
        add_byte(len[23:16], 1'b0, 1'b0);
        add_byte(len[15:8], 1'b0, 1'b0);
        add_byte(len[7:0], seg_end, str_end);
    endtask

    // mostly well-formed streams, some truncated, cut short or garbage
    task automatic add_random_stream();
        logic [7:0]  body[$];
        bit          mid_len[$];
        logic [31:0] len;
        int unsigned n_hdr;
        int unsigned mode;
        int unsigned cut;
        logic        seg;
        n_hdr = $urandom_range(1, 6);
        mode  = $urandom_range(0, 9);
        for (int h = 0; h < n_hdr; h++) begin
            len = ($urandom_range(0, 6) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
            for (int k = 0; k < 4; k++) begin
                body    = {body, len[31 - 8 * k -: 8]};
                mid_len = {mid_len, bit'(k != 3)};
            end
            for (int k = 0; k < len; k++) begin
                body    = {body, 8'($urandom)};
                mid_len = {mid_len, 1'b0};
            end
        end
        // stream cut short, usually inside a payload
        if (mode == 1) begin
            cut = $urandom_range(1, body.size() - 1);
            while (body.size() > cut) begin
                void'(body.pop_back());
                void'(mid_len.pop_back());
            end
        end
        // unframed noise
        if (mode == 2) begin
            body.delete();
            mid_len.delete();
            cut = $urandom_range(1, 20);
            for (int k = 0; k < cut; k++) begin
                body    = {body, 8'($urandom)};
                mid_len = {mid_len, 1'b0};
            end
        end
        for (int i = 0; i < body.size(); i++) begin
            if (mid_len[i])
                seg = (mode == 0) && ($urandom_range(0, 3) == 0);
            else
                seg = ($urandom_range(0, 5) == 0);
            if (i == body.size() - 1)
                seg = ($urandom_range(0, 3) != 0);
            add_byte(body[i], seg, i == body.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (byte_q.size() != 0 || i_valid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial begin
        int unsigned random_items;
        int unsigned calm_items;
        int unsigned before_cnt;
        int unsigned next_pause;
        clear_deframer();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, truncated lengths and unfinished payloads
        add_length(32'd2, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_length(32'd0, 1'b1, 1'b1);
        // length cut by a segment end, then silence until stream end
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h55, 1'b0, 1'b1);
        // maximum length ending the stream on its own announcement
        add_length(32'hFFFF_FFFF, 1'b0, 1'b1);
        // stream ending inside a payload
        add_length(32'd3, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b0, 1'b0);
        add_byte(8'hC3, 1'b0, 1'b1);
        // stream end without segment end inside a length
        add_byte(8'h12, 1'b0, 1'b0);
        add_byte(8'h34, 1'b0, 1'b1);
        wait_drained();

        // long stretch with no idling on either side
        calm       = 1'b1;
        calm_items = 0;
        while (calm_items < CALM_ITEMS) begin
            before_cnt = byte_q.size();
            add_random_stream();
            calm_items += byte_q.size() - before_cnt;
        end
        wait_drained();
        calm = 1'b0;

        // random streams, with the sender holding off now and then
        random_items = 0;
        next_pause   = PAUSE_EVERY;
        while (random_items < RANDOM_ITEMS) begin
            before_cnt = byte_q.size();
            add_random_stream();
            random_items += byte_q.size() - before_cnt;
            if (random_items >= next_pause) begin
                wait_drained();
                next_pause += PAUSE_EVERY;
            end
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d results: %0d tile headers, %0d payload bytes",
                 bytes_sent, results_seen, headers_seen, payload_seen);
        $display("Errors seen: truncated length %0d, unfinished payload %0d, tile limit %0d",
                 errors_seen[1], errors_seen[2], errors_seen[3]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
